FILE: sv/assert_macros.svh
// Assertion macros used by the game-pad poll master engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define GSPM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define GSPM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/gspm_pkg.sv
// Types, constants and the command byte table of the game-pad poll master.
`timescale 1ns / 1ps

package gspm_pkg;

  // Frame length for the long frame kinds, and the widest frame the counters support.
  localparam int unsigned FrameBytesDef = 9;
  localparam int unsigned ByteIdxW      = 4;
  localparam int unsigned ReportSlots   = 9;

  // Fixed bytes on the wire.
  localparam logic [7:0] ByteStart     = 8'h01;
  localparam logic [7:0] BytePoll      = 8'h42;
  localparam logic [7:0] ByteConfig    = 8'h43;
  localparam logic [7:0] ByteAnalog    = 8'h44;
  localparam logic [7:0] ByteVibMap    = 8'h4D;
  localparam logic [7:0] ByteFill      = 8'h5A;
  localparam logic [7:0] ByteZero      = 8'h00;
  localparam logic [7:0] ByteOne       = 8'h01;
  localparam logic [7:0] ModeRedAnalog = 8'h73;

  // Register reset values.
  localparam logic [7:0] HalfBitReset   = 8'd3;
  localparam logic [7:0] ByteGapReset   = 8'd16;
  localparam logic [7:0] FrameGapReset  = 8'd16;
  localparam logic       AnalogSelReset = 1'b1;
  localparam logic [7:0] LockByteReset  = 8'hEE;

  typedef enum logic [2:0] {
    CFG_HALF_BIT   = 3'd0,
    CFG_BYTE_GAP   = 3'd1,
    CFG_FRAME_GAP  = 3'd2,
    CFG_ANALOG_SEL = 3'd3,
    CFG_LOCK_BYTE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_POLL       = 3'd0,
    KIND_MODE_CHECK = 3'd1,
    KIND_VIBRATE    = 3'd2,
    KIND_SHORT_POLL = 3'd3,
    KIND_ENTER_CFG  = 3'd4,
    KIND_SET_ANALOG = 3'd5,
    KIND_VIB_ENABLE = 3'd6,
    KIND_EXIT_CFG   = 3'd7
  } kind_e;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_LEAD  = 6'b000010,
    PH_HIGH  = 6'b000100,
    PH_LOW   = 6'b001000,
    PH_BGAP  = 6'b010000,
    PH_TRAIL = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] half_bit_ticks;
    logic [7:0] byte_gap_ticks;
    logic [7:0] frame_gap_ticks;
    logic       analog_select;
    logic [7:0] mode_lock_byte;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic [2:0] cmd;
    logic [7:0] motor_small;
    logic [7:0] motor_large;
    logic       data_in;
  } in_item_t;

  typedef struct packed {
    logic        select_n;
    logic        clock_out;
    logic        data_out;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  mode_id;
    logic        red_mode;
    logic [15:0] buttons;
    logic [7:0]  stick_byte5;
    logic [7:0]  stick_byte6;
    logic [7:0]  stick_byte7;
    logic [7:0]  stick_byte8;
  } out_item_t;

  // Command byte sent at a given byte position of a frame kind.
  function automatic logic [7:0] cmd_byte(input kind_e kind, input logic [ByteIdxW-1:0] idx,
                                          input logic [7:0] motor_sm,
                                          input logic [7:0] motor_lg,
                                          input cfg_t cfg);
    logic [7:0] b;
    b = (kind == KIND_EXIT_CFG) ? ByteFill : ByteZero;
    unique case (idx)
      4'd0: b = ByteStart;
      4'd1: begin
        unique case (kind)
          KIND_ENTER_CFG, KIND_EXIT_CFG: b = ByteConfig;
          KIND_SET_ANALOG:               b = ByteAnalog;
          KIND_VIB_ENABLE:               b = ByteVibMap;
          default:                       b = BytePoll;
        endcase
      end
      4'd2: b = ByteZero;
      4'd3: begin
        unique case (kind)
          KIND_VIBRATE:    b = motor_sm;
          KIND_ENTER_CFG:  b = ByteOne;
          KIND_SET_ANALOG: b = {7'd0, cfg.analog_select};
          default:         b = ByteZero;
        endcase
      end
      4'd4: begin
        unique case (kind)
          KIND_VIBRATE:    b = motor_lg;
          KIND_SET_ANALOG: b = cfg.mode_lock_byte;
          KIND_VIB_ENABLE: b = ByteOne;
          KIND_EXIT_CFG:   b = ByteFill;
          default:         b = ByteZero;
        endcase
      end
      default: ;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/gamepad_serial_poll_master_top.sv
// Top level of the game-pad serial poll master.
`timescale 1ns / 1ps

// Game-pad serial poll master. Every input transaction is one tick of the bit-banged
// link: it carries the sampled pad data line and, while the block is idle, an optional
// start request with the frame kind and the two motor bytes. Each accepted tick yields
// exactly one output transaction in the next cycle, showing chip select, clock and command
// data levels for that tick, the busy flag, a one-tick done flag and, on the done tick,
// the mode byte, red-mode flag, inverted button word and four stick bytes (all zero on
// other ticks). A tick is accepted in every cycle unless the output stalls: the sequencer,
// reply store and result logic are combinational over the registered state, so the rate is
// one tick per clock, limited only by the output register, which stalls the input only
// while a result waits and the output is stalled. All reply slots are cleared when a frame
// starts, and a read past the frame store reads zero. Configuration writes complete in the
// cycle they are presented and should be made only while no frame is running. Nothing needs
// a clearing pass after reset.
module gamepad_serial_poll_master_top #(
  parameter int unsigned FRAME_BYTES = gspm_pkg::FrameBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gspm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gspm_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import gspm_pkg::*;

  cfg_t      cfg;
  out_item_t result;
  out_item_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      step;

  // The input is held back only when a finished result is still waiting downstream.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign step        = in_valid_i && !in_stall_o;
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  gspm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gspm_engine #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_i),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: sv/gspm_cfg.sv
// Configuration register file of the game-pad poll master.
`timescale 1ns / 1ps

module gspm_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  output gspm_pkg::cfg_t   cfg_o
);
  import gspm_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; the register file never holds off a write.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HALF_BIT:   cfg_d.half_bit_ticks  = cfg_data_i;
        CFG_BYTE_GAP:   cfg_d.byte_gap_ticks  = cfg_data_i;
        CFG_FRAME_GAP:  cfg_d.frame_gap_ticks = cfg_data_i;
        CFG_ANALOG_SEL: cfg_d.analog_select   = cfg_data_i[0];
        CFG_LOCK_BYTE:  cfg_d.mode_lock_byte  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks  <= HalfBitReset;
      cfg_q.byte_gap_ticks  <= ByteGapReset;
      cfg_q.frame_gap_ticks <= FrameGapReset;
      cfg_q.analog_select   <= AnalogSelReset;
      cfg_q.mode_lock_byte  <= LockByteReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/gspm_engine.sv
// Frame sequencer, reply store and per-tick result logic of the game-pad poll master.
`timescale 1ns / 1ps

module gspm_engine #(
  parameter int unsigned FRAME_BYTES = gspm_pkg::FrameBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  gspm_pkg::in_item_t  item_i,
  input  gspm_pkg::cfg_t      cfg_i,
  output gspm_pkg::out_item_t result_o
);
  import gspm_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IdxW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned LenW = ByteIdxW + 1;

  phase_e                phase_q, phase_d;
  logic [7:0]            tick_q, tick_d;
  logic [2:0]            bit_q, bit_d;
  logic [ByteIdxW-1:0]   byte_q, byte_d;
  kind_e                 kind_q, kind_d;
  logic [7:0]            small_q, small_d;
  logic [7:0]            large_q, large_d;
  logic [7:0]            reply_q [FRAME_BYTES];
  logic [7:0]            reply_d [FRAME_BYTES];
  logic                  done;

  logic [7:0]            half;
  logic [7:0]            tick_inc;
  logic [ByteIdxW-1:0]   byte_nxt;
  logic [LenW-1:0]       frame_len;
  logic                  frame_over;
  logic [7:0]            slot [ReportSlots];
  logic [7:0]            tx_byte;
  logic                  in_frame;
  logic                  in_bit;

  assign half     = (cfg_i.half_bit_ticks == 8'd0) ? 8'd1 : cfg_i.half_bit_ticks;
  assign tick_inc = tick_q + 8'd1;
  assign byte_nxt = byte_q + ByteIdxW'(1);

  always_comb begin
    unique case (kind_q)
      KIND_MODE_CHECK:                  frame_len = LenW'(2);
      KIND_SHORT_POLL, KIND_VIB_ENABLE: frame_len = LenW'(5);
      default:                          frame_len = LenW'(FRAME_BYTES);
    endcase
  end

  // The byte counter wraps to zero on the longest frames, which also ends the frame.
  assign frame_over = ({1'b0, byte_nxt} >= frame_len) || (byte_nxt == '0);

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    kind_d  = kind_q;
    small_d = small_q;
    large_d = large_q;
    reply_d = reply_q;
    done    = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (item_i.start_req) begin
            kind_d  = kind_e'(item_i.cmd);
            small_d = item_i.motor_small;
            large_d = item_i.motor_large;
            for (int k = 0; k < FRAME_BYTES; k++) begin
              reply_d[k] = 8'd0;
            end
            byte_d  = '0;
            bit_d   = 3'd0;
            tick_d  = 8'd0;
            phase_d = (cfg_i.frame_gap_ticks != 8'd0) ? PH_LEAD : PH_HIGH;
          end
        end
        PH_LEAD: begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.frame_gap_ticks) begin
            phase_d = PH_HIGH;
            tick_d  = 8'd0;
          end
        end
        PH_HIGH: begin
          tick_d = tick_inc;
          if (tick_inc >= half) begin
            phase_d = PH_LOW;
            tick_d  = 8'd0;
          end
        end
        PH_LOW: begin
          tick_d = tick_inc;
          if (tick_inc >= half) begin
            tick_d = 8'd0;
            if (item_i.data_in && ({1'b0, byte_q} < LenW'(FRAME_BYTES))) begin
              reply_d[byte_q[IdxW-1:0]][bit_q] = 1'b1;
            end
            if (bit_q == 3'd7) begin
              if (cfg_i.byte_gap_ticks != 8'd0) begin
                phase_d = PH_BGAP;
              end else begin
                byte_d = byte_nxt;
                bit_d  = 3'd0;
                if (frame_over) begin
                  if (cfg_i.frame_gap_ticks != 8'd0) begin
                    phase_d = PH_TRAIL;
                  end else begin
                    phase_d = PH_IDLE;
                    done    = 1'b1;
                  end
                end else begin
                  phase_d = PH_HIGH;
                end
              end
            end else begin
              bit_d   = bit_q + 3'd1;
              phase_d = PH_HIGH;
            end
          end
        end
        PH_BGAP: begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.byte_gap_ticks) begin
            tick_d = 8'd0;
            byte_d = byte_nxt;
            bit_d  = 3'd0;
            if (frame_over) begin
              if (cfg_i.frame_gap_ticks != 8'd0) begin
                phase_d = PH_TRAIL;
              end else begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end else begin
              phase_d = PH_HIGH;
            end
          end
        end
        PH_TRAIL: begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.frame_gap_ticks) begin
            phase_d = PH_IDLE;
            tick_d  = 8'd0;
            done    = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          tick_d  = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= 8'd0;
      bit_q   <= 3'd0;
      byte_q  <= '0;
      kind_q  <= KIND_POLL;
      small_q <= 8'd0;
      large_q <= 8'd0;
      for (int k = 0; k < FRAME_BYTES; k++) begin
        reply_q[k] <= 8'd0;
      end
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      kind_q  <= kind_d;
      small_q <= small_d;
      large_q <= large_d;
      reply_q <= reply_d;
    end
  end

  // Report slots past the end of the store read as zero.
  for (genvar k = 0; k < ReportSlots; k++) begin : g_slot
    if (k < FRAME_BYTES) begin : g_real
      assign slot[k] = reply_d[k];
    end else begin : g_none
      assign slot[k] = 8'd0;
    end
  end

  assign tx_byte  = cmd_byte(kind_d, byte_d, small_d, large_d, cfg_i);
  assign in_bit   = (phase_d == PH_HIGH) || (phase_d == PH_LOW);
  assign in_frame = in_bit || (phase_d == PH_LEAD) || (phase_d == PH_BGAP);

  always_comb begin
    result_o           = '0;
    result_o.select_n  = !in_frame;
    result_o.clock_out = (phase_d != PH_LOW);
    result_o.data_out  = in_bit && tx_byte[bit_d];
    result_o.busy_res  = (phase_d != PH_IDLE);
    result_o.done_res  = done;
    if (done) begin
      result_o.mode_id     = slot[1];
      result_o.red_mode    = (slot[1] == ModeRedAnalog);
      result_o.buttons     = ~{slot[4], slot[3]};
      result_o.stick_byte5 = slot[5];
      result_o.stick_byte6 = slot[6];
      result_o.stick_byte7 = slot[7];
      result_o.stick_byte8 = slot[8];
    end
  end

  `GSPM_ASSERT(a_hold_without_step, clk_i, rst_ni,
    !step_i |=> $stable(phase_q) && $stable(tick_q) && $stable(byte_q),
    "sequencer state moved without an accepted tick")
  `GSPM_ASSERT(a_idle_stays_idle, clk_i, rst_ni,
    step_i && (phase_q == PH_IDLE) && !item_i.start_req |=> (phase_q == PH_IDLE),
    "frame started without a start request")
  `GSPM_ASSERT(a_idle_bit_clear, clk_i, rst_ni,
    (phase_q == PH_IDLE) |-> (bit_q == 3'd0),
    "bit counter not cleared while idle")
  `GSPM_ASSERT(a_done_ends_frame, clk_i, rst_ni,
    step_i && done |=> (phase_q == PH_IDLE),
    "frame reported done but sequencer not idle")

endmodule
